@@ design/tvn_pkg.sv @@
// ----------------------------------------------------------------------------
// tvn_pkg: shared types and constants for the tiling value noise block
// Hash constants, octave weights, register codes and the stage enable bundle.
// ----------------------------------------------------------------------------
package tvn_pkg;

  // Default parameter values
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_LATTICE_DEF = 256;

  // Pipeline depth: register stages from input to result
  localparam int NSTG = 9;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int NOISE_W    = 16;
  localparam int CORNER_W   = 24;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Corner hash constants
  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam int          HASH_SHIFT_A = 13;
  localparam int          HASH_SHIFT_B = 16;

  // Octave lattice sizes and Q0.16 weights for the fractal sum
  localparam int OCT_G0 = 4;
  localparam int OCT_G1 = 8;
  localparam int OCT_G2 = 16;
  localparam logic [WEIGHT_W-1:0] W_OCT4  = 16'd36045;
  localparam logic [WEIGHT_W-1:0] W_OCT8  = 16'd19661;
  localparam logic [WEIGHT_W-1:0] W_OCT16 = 16'd9830;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] LAT_RESET = 9'd4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_LATTICE = 2'd1
  } cfg_reg_t;

  // Operating modes
  typedef enum logic {
    MODE_FBM    = 1'b0,
    MODE_SINGLE = 1'b1
  } mode_t;

  // Per-stage load enables, one per register stage
  typedef struct packed {
    logic lat;   // cell and in-cell fraction
    logic hmul;  // hash first multiply, fade square
    logic hmix;  // hash mix multiply, fade cubic
    logic lmul;  // horizontal lerp products
    logic lsum;  // horizontal lerp sums
    logic vmul;  // vertical lerp products
    logic vsum;  // vertical lerp sum, octave value
    logic wmul;  // weighted octave products
    logic outr;  // result register
  } pipe_en_t;

endpackage

@@ design/tvn_hash.sv @@
// ----------------------------------------------------------------------------
// tvn_hash: two-stage corner hash
// Integer multiply-xorshift hash of a lattice corner, one corner per beat.
// ----------------------------------------------------------------------------
module tvn_hash #(
  parameter int IDX_W = 8
) (
  input  logic              clk,
  input  logic              en_mul,
  input  logic              en_mix,
  input  logic [IDX_W-1:0]  x,
  input  logic [IDX_W-1:0]  y,
  output logic [31:0]       h
);

  logic [31:0] n0;
  logic [31:0] n0_next;
  logic [31:0] n1;

  // Combine the two coordinates, all arithmetic modulo 2^32
  assign n0_next = (32'(x) + 32'd1) * tvn_pkg::HASH_MUL_X
                 + (32'(y) * 32'd3 + 32'd1) * tvn_pkg::HASH_MUL_Y;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      n0 <= n0_next;
    end
  end

  // Xorshift and mix multiply
  assign n1 = n0 ^ (n0 >> tvn_pkg::HASH_SHIFT_A);

  always_ff @(posedge clk) begin
    if (en_mix) begin
      h <= n1 * tvn_pkg::HASH_MUL_MIX;
    end
  end

endmodule

@@ design/tvn_octave.sv @@
// ----------------------------------------------------------------------------
// tvn_octave: one octave of tiling value noise
// Cell lookup, corner hashes, smoothstep fade and bilinear interpolation over
// seven register stages. The result is Q0.24.
// ----------------------------------------------------------------------------
module tvn_octave #(
  parameter int FRAC_BITS   = tvn_pkg::FRAC_BITS_DEF,
  parameter int MAX_LATTICE = tvn_pkg::MAX_LATTICE_DEF
) (
  input  logic                          clk,
  input  tvn_pkg::pipe_en_t             en,
  input  logic [tvn_pkg::COORD_W-1:0]   u,
  input  logic [tvn_pkg::COORD_W-1:0]   v,
  input  logic [$clog2(MAX_LATTICE+1)-1:0] g,
  output logic [tvn_pkg::CORNER_W-1:0]  oct
);

  localparam int FB   = FRAC_BITS;
  localparam int CRW  = tvn_pkg::COORD_W;
  localparam int LW   = $clog2(MAX_LATTICE + 1);
  localparam int IW   = $clog2(MAX_LATTICE);
  localparam int PW   = CRW + LW;
  localparam int CW   = tvn_pkg::CORNER_W;
  localparam int LPW  = CW + FB + 1;
  localparam int SW   = LPW + 1;
  localparam int MW   = 2 * FB + 2;
  localparam int SH_L = (FB >= CRW) ? FB - CRW : 0;
  localparam int SH_R = (FB >= CRW) ? 0 : CRW - FB;
  localparam logic [FB+1:0] THREE_ONE = (FB + 2)'(3) << FB;
  localparam logic [FB:0]   ONE       = (FB + 1)'(1) << FB;

  // Stage 1: cell index and in-cell fraction
  logic [PW-1:0]  fx_full;
  logic [PW-1:0]  fy_full;
  logic [IW-1:0]  x0;
  logic [IW-1:0]  y0;
  logic [CRW-1:0] frac_x;
  logic [CRW-1:0] frac_y;

  assign fx_full = PW'(u) * PW'(g);
  assign fy_full = PW'(v) * PW'(g);

  always_ff @(posedge clk) begin
    if (en.lat) begin
      x0     <= fx_full[CRW +: IW];
      y0     <= fy_full[CRW +: IW];
      frac_x <= fx_full[CRW-1:0];
      frac_y <= fy_full[CRW-1:0];
    end
  end

  // Stage 2: upper corners with wrap, fraction rescale and square
  logic [LW-1:0]     x0p1;
  logic [LW-1:0]     y0p1;
  logic [IW-1:0]     x1;
  logic [IW-1:0]     y1;
  logic [FB+CRW-1:0] txw;
  logic [FB+CRW-1:0] tyw;
  logic [FB-1:0]     tx_c;
  logic [FB-1:0]     ty_c;
  logic [2*FB-1:0]   ttx;
  logic [2*FB-1:0]   tty;
  logic [FB-1:0]     tx;
  logic [FB-1:0]     ty;
  logic [FB-1:0]     t2x;
  logic [FB-1:0]     t2y;

  assign x0p1 = LW'(x0) + LW'(1);
  assign y0p1 = LW'(y0) + LW'(1);
  assign x1   = (x0p1 >= g) ? '0 : x0p1[IW-1:0];
  assign y1   = (y0p1 >= g) ? '0 : y0p1[IW-1:0];

  assign txw  = ((FB + CRW)'(frac_x) << SH_L) >> SH_R;
  assign tyw  = ((FB + CRW)'(frac_y) << SH_L) >> SH_R;
  assign tx_c = txw[FB-1:0];
  assign ty_c = tyw[FB-1:0];
  assign ttx  = (2 * FB)'(tx_c) * (2 * FB)'(tx_c);
  assign tty  = (2 * FB)'(ty_c) * (2 * FB)'(ty_c);

  always_ff @(posedge clk) begin
    if (en.hmul) begin
      tx  <= tx_c;
      ty  <= ty_c;
      t2x <= ttx[2*FB-1:FB];
      t2y <= tty[2*FB-1:FB];
    end
  end

  // Corner hashes: a = (x0,y0), b = (x1,y0), c = (x0,y1), d = (x1,y1)
  logic [31:0] h_a;
  logic [31:0] h_b;
  logic [31:0] h_c;
  logic [31:0] h_d;

  tvn_hash #(.IDX_W(IW)) u_hash_a (
    .clk(clk), .en_mul(en.hmul), .en_mix(en.hmix), .x(x0), .y(y0), .h(h_a)
  );
  tvn_hash #(.IDX_W(IW)) u_hash_b (
    .clk(clk), .en_mul(en.hmul), .en_mix(en.hmix), .x(x1), .y(y0), .h(h_b)
  );
  tvn_hash #(.IDX_W(IW)) u_hash_c (
    .clk(clk), .en_mul(en.hmul), .en_mix(en.hmix), .x(x0), .y(y1), .h(h_c)
  );
  tvn_hash #(.IDX_W(IW)) u_hash_d (
    .clk(clk), .en_mul(en.hmul), .en_mix(en.hmix), .x(x1), .y(y1), .h(h_d)
  );

  // Stage 3: fade cubic term, s = t2 * (3 - 2t)
  logic [FB+1:0] kx;
  logic [FB+1:0] ky;
  logic [MW-1:0] mx;
  logic [MW-1:0] my;
  logic [FB:0]   sx3;
  logic [FB:0]   sy3;

  assign kx = THREE_ONE - ((FB + 2)'(tx) << 1);
  assign ky = THREE_ONE - ((FB + 2)'(ty) << 1);
  assign mx = MW'(t2x) * MW'(kx);
  assign my = MW'(t2y) * MW'(ky);

  always_ff @(posedge clk) begin
    if (en.hmix) begin
      sx3 <= mx[2*FB:FB];
      sy3 <= my[2*FB:FB];
    end
  end

  // Stage 4: finish corner values, horizontal lerp products
  logic [31:0]    hx_a;
  logic [31:0]    hx_b;
  logic [31:0]    hx_c;
  logic [31:0]    hx_d;
  logic [FB:0]    omsx;
  logic [LPW-1:0] p_a;
  logic [LPW-1:0] p_b;
  logic [LPW-1:0] p_c;
  logic [LPW-1:0] p_d;
  logic [FB:0]    sy4;

  assign hx_a = h_a ^ (h_a >> tvn_pkg::HASH_SHIFT_B);
  assign hx_b = h_b ^ (h_b >> tvn_pkg::HASH_SHIFT_B);
  assign hx_c = h_c ^ (h_c >> tvn_pkg::HASH_SHIFT_B);
  assign hx_d = h_d ^ (h_d >> tvn_pkg::HASH_SHIFT_B);
  assign omsx = ONE - sx3;

  always_ff @(posedge clk) begin
    if (en.lmul) begin
      p_a <= LPW'(hx_a[CW-1:0]) * LPW'(omsx);
      p_b <= LPW'(hx_b[CW-1:0]) * LPW'(sx3);
      p_c <= LPW'(hx_c[CW-1:0]) * LPW'(omsx);
      p_d <= LPW'(hx_d[CW-1:0]) * LPW'(sx3);
      sy4 <= sy3;
    end
  end

  // Stage 5: horizontal lerp sums
  logic [SW-1:0] sum_top;
  logic [SW-1:0] sum_bot;
  logic [CW-1:0] top;
  logic [CW-1:0] bot;
  logic [FB:0]   sy5;

  assign sum_top = SW'(p_a) + SW'(p_b);
  assign sum_bot = SW'(p_c) + SW'(p_d);

  always_ff @(posedge clk) begin
    if (en.lsum) begin
      top <= sum_top[FB +: CW];
      bot <= sum_bot[FB +: CW];
      sy5 <= sy4;
    end
  end

  // Stage 6: vertical lerp products
  logic [LPW-1:0] q_top;
  logic [LPW-1:0] q_bot;

  always_ff @(posedge clk) begin
    if (en.vmul) begin
      q_top <= LPW'(top) * LPW'(ONE - sy5);
      q_bot <= LPW'(bot) * LPW'(sy5);
    end
  end

  // Stage 7: vertical lerp sum
  logic [SW-1:0] sum_v;

  assign sum_v = SW'(q_top) + SW'(q_bot);

  always_ff @(posedge clk) begin
    if (en.vsum) begin
      oct <= sum_v[FB +: CW];
    end
  end

endmodule

@@ design/tvn_combine.sv @@
// ----------------------------------------------------------------------------
// tvn_combine: octave weighting and result register
// Weights and sums three octaves to a saturated Q0.16, or scales one octave to Q0.16.
// ----------------------------------------------------------------------------
module tvn_combine (
  input  logic                          clk,
  input  tvn_pkg::pipe_en_t             en,
  input  tvn_pkg::mode_t                mode,
  input  logic [tvn_pkg::CORNER_W-1:0]  oct0,
  input  logic [tvn_pkg::CORNER_W-1:0]  oct1,
  input  logic [tvn_pkg::CORNER_W-1:0]  oct2,
  output logic [tvn_pkg::NOISE_W-1:0]   noise_value
);

  localparam int CW  = tvn_pkg::CORNER_W;
  localparam int NW  = tvn_pkg::NOISE_W;
  localparam int PRW = tvn_pkg::WEIGHT_W + CW;
  localparam int AW  = PRW + 2;
  localparam int RW  = AW - CW;

  // Stage 8: weighted products and single-octave scale
  logic [PRW-1:0] wp0;
  logic [PRW-1:0] wp1;
  logic [PRW-1:0] wp2;
  logic [NW-1:0]  single;

  always_ff @(posedge clk) begin
    if (en.wmul) begin
      wp0    <= PRW'(tvn_pkg::W_OCT4)  * PRW'(oct0);
      wp1    <= PRW'(tvn_pkg::W_OCT8)  * PRW'(oct1);
      wp2    <= PRW'(tvn_pkg::W_OCT16) * PRW'(oct2);
      single <= oct0[CW-1:CW-NW];
    end
  end

  // Stage 9: sum, drop the fraction, saturate
  logic [AW-1:0] acc;
  logic [RW-1:0] res;
  logic [NW-1:0] fbm_value;

  assign acc       = AW'(wp0) + AW'(wp1) + AW'(wp2);
  assign res       = acc[AW-1:CW];
  assign fbm_value = (|res[RW-1:NW]) ? '1 : res[NW-1:0];

  always_ff @(posedge clk) begin
    if (en.outr) begin
      noise_value <= (mode == tvn_pkg::MODE_SINGLE) ? single : fbm_value;
    end
  end

endmodule

@@ design/tiling_value_noise_fbm.sv @@
// ----------------------------------------------------------------------------
// tiling_value_noise_fbm: tileable value noise with a three-octave fractal sum
// Hashed lattice corners, smoothstep fade and bilinear interpolation per
// octave; three octave lanes run side by side and merge at the end.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  coord     coord_valid/coord_ready   u_frac[15:0], v_frac[15:0]
//  noise     noise_valid/noise_ready   noise_value[15:0]
//  cfg       cfg_valid/cfg_ready       cfg_index[1:0], cfg_data[8:0]
//
//  One beat enters per cycle unless a full pipeline is stalled by noise_ready;
//  each beat passes the nine register stages (hash multiplies and lerp multiplies).
//  Stages advance on their own: a bubble ahead of a stalled stage is filled,
//  and a full pipeline holds every beat until noise_ready frees the end.
//  Synchronous reset empties the pipeline and sets mode 0, lattice size 4.
//  cfg_ready is always high.
//
module tiling_value_noise_fbm #(
  parameter int FRAC_BITS   = tvn_pkg::FRAC_BITS_DEF,
  parameter int MAX_LATTICE = tvn_pkg::MAX_LATTICE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            coord_valid,
  output logic                            coord_ready,
  input  logic [tvn_pkg::COORD_W-1:0]     u_frac,
  input  logic [tvn_pkg::COORD_W-1:0]     v_frac,
  output logic                            noise_valid,
  input  logic                            noise_ready,
  output logic [tvn_pkg::NOISE_W-1:0]     noise_value
);

  localparam int LW   = $clog2(MAX_LATTICE + 1);
  localparam int NSTG = tvn_pkg::NSTG;
  localparam int CW   = tvn_pkg::CORNER_W;

  // Configuration registers
  tvn_pkg::mode_t                  mode;
  logic [tvn_pkg::CFG_DATA_W-1:0]  lattice;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= tvn_pkg::MODE_FBM;
      lattice <= tvn_pkg::LAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tvn_pkg::cfg_reg_t'(cfg_index))
        tvn_pkg::REG_MODE:    mode    <= tvn_pkg::mode_t'(cfg_data[0]);
        tvn_pkg::REG_LATTICE: lattice <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the lattice size into 1..MAX_LATTICE
  logic [LW-1:0] g_sat;
  logic [LW-1:0] g_lane0;

  always_comb begin
    if (lattice == '0) begin
      g_sat = LW'(1);
    end else if (32'(lattice) > 32'(MAX_LATTICE)) begin
      g_sat = LW'(MAX_LATTICE);
    end else begin
      g_sat = LW'(lattice);
    end
  end

  assign g_lane0 = (mode == tvn_pkg::MODE_SINGLE) ? g_sat : LW'(tvn_pkg::OCT_G0);

  // Stage valid bits and load enables; a stage loads when empty or draining
  logic [NSTG-1:0]   vld;
  logic [NSTG-1:0]   en_vec;
  tvn_pkg::pipe_en_t en;

  always_comb begin
    en_vec[NSTG-1] = !vld[NSTG-1] || noise_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en_vec[i] = !vld[i] || en_vec[i+1];
    end
  end

  always_comb begin
    en.lat  = en_vec[0];
    en.hmul = en_vec[1];
    en.hmix = en_vec[2];
    en.lmul = en_vec[3];
    en.lsum = en_vec[4];
    en.vmul = en_vec[5];
    en.vsum = en_vec[6];
    en.wmul = en_vec[7];
    en.outr = en_vec[8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en_vec[0]) begin
        vld[0] <= coord_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en_vec[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign coord_ready = en_vec[0];
  assign noise_valid = vld[NSTG-1];

  // Octave lanes
  logic [CW-1:0] oct0;
  logic [CW-1:0] oct1;
  logic [CW-1:0] oct2;

  tvn_octave #(.FRAC_BITS(FRAC_BITS), .MAX_LATTICE(MAX_LATTICE)) u_oct0 (
    .clk(clk), .en(en), .u(u_frac), .v(v_frac), .g(g_lane0), .oct(oct0)
  );
  tvn_octave #(.FRAC_BITS(FRAC_BITS), .MAX_LATTICE(MAX_LATTICE)) u_oct1 (
    .clk(clk), .en(en), .u(u_frac), .v(v_frac), .g(LW'(tvn_pkg::OCT_G1)), .oct(oct1)
  );
  tvn_octave #(.FRAC_BITS(FRAC_BITS), .MAX_LATTICE(MAX_LATTICE)) u_oct2 (
    .clk(clk), .en(en), .u(u_frac), .v(v_frac), .g(LW'(tvn_pkg::OCT_G2)), .oct(oct2)
  );

  // Weighting and result register
  tvn_combine u_combine (
    .clk(clk), .en(en), .mode(mode),
    .oct0(oct0), .oct1(oct1), .oct2(oct2),
    .noise_value(noise_value)
  );

`ifndef NO_ASSERTIONS
  // Input is refused only when every stage holds a beat and the end is stalled
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    coord_ready |-> (noise_ready || !(&vld)))
    else $error("coord_ready high with a full, stalled pipeline");

  // An accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && coord_ready) |=> vld[0])
    else $error("accepted coordinate lost at stage 1");

  // A stalled middle stage keeps its beat
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !en_vec[4]) |=> vld[4])
    else $error("stalled stage dropped its beat");
`endif

endmodule
